// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros clocked on aclk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== src/lskc_pkg.sv =====
// ----------------------------------------------------------------------------
// lskc_pkg
// constants, types and elaboration-time matrices of the seed key unit
// ----------------------------------------------------------------------------
package lskc_pkg;

    localparam int ROUNDS  = 64;
    localparam int LFSR_W  = 24;
    localparam int SEED_W  = 64;
    localparam int HALF_W  = 32;
    localparam int KEEP_W  = 24;
    localparam int FILL_W  = 40;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    typedef logic [LFSR_W-1:0] lfsr_t;
    typedef logic [SEED_W-1:0] seed_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [LFSR_W-1:0][LFSR_W-1:0] start_matrix_t;
    typedef logic [LFSR_W-1:0][SEED_W-1:0] seed_matrix_t;

    localparam lfsr_t TAPS = 24'h909028;

    localparam level_t LEVEL_ONE       = 8'h01;
    localparam level_t LEVEL_THREE     = 8'h03;
    localparam level_t LEVEL_SIXTY_ONE = 8'h61;

    localparam cfg_idx_t CFG_LFSR_START      = 8'd0;
    localparam cfg_idx_t CFG_LEVEL_ONE_FILL  = 8'd1;
    localparam cfg_idx_t CFG_LEVEL_THREE_FILL = 8'd2;
    localparam cfg_idx_t CFG_LEVEL_SIXTY_ONE_FILL = 8'd3;

    localparam lfsr_t START_RESET           = 24'hC541A9;
    localparam fill_t FILL_ONE_RESET        = 40'h6E61776F52;
    localparam fill_t FILL_THREE_RESET      = 40'h7241E4895A;
    localparam fill_t FILL_SIXTY_ONE_RESET  = 40'h3868045A4D;

    // bit-serial galois register, used only to build the matrices
    function automatic lfsr_t lfsr_run(lfsr_t start, seed_t seed);
        lfsr_t r;
        logic  fb;
        r = start;
        for (int i = 0; i < ROUNDS; i++) begin
            fb = seed[i] ^ r[0];
            r  = {1'b0, r[LFSR_W-1:1]} ^ (fb ? TAPS : '0);
        end
        return r;
    endfunction

    function automatic start_matrix_t build_start_matrix();
        start_matrix_t m;
        lfsr_t         col;
        for (int k = 0; k < LFSR_W; k++) begin
            col = lfsr_run(lfsr_t'(1) << k, '0);
            for (int j = 0; j < LFSR_W; j++) begin
                m[j][k] = col[j];
            end
        end
        return m;
    endfunction

    function automatic seed_matrix_t build_seed_matrix();
        seed_matrix_t m;
        lfsr_t        col;
        for (int k = 0; k < SEED_W; k++) begin
            col = lfsr_run('0, seed_t'(1) << k);
            for (int j = 0; j < LFSR_W; j++) begin
                m[j][k] = col[j];
            end
        end
        return m;
    endfunction

    // row j: which start bits and seed bits feed final register bit j
    localparam start_matrix_t START_MATRIX = build_start_matrix();
    localparam seed_matrix_t  SEED_MATRIX  = build_seed_matrix();

    // nibble shuffle into key bytes 0, 1, 2 (byte 0 on top)
    function automatic lfsr_t key_shuffle(lfsr_t r);
        return {r[11:8], r[7:4], r[15:12], r[23:20], r[3:0], r[19:16]};
    endfunction

endpackage

// ===== src/lfsr_seed_key_calc_unit.sv =====
// path: an accepted input is held in the input register, and its key is loaded into
// the result register when that stage may advance (input register, result register)
// throughput: one item per cycle unless m_ready stalls the output, set by the single
// xor-parity network between the two registers that replaces the 64 shift register steps
// reset: synchronous active-low aresetn clears both stage valids and loads the
// default start value and level fills
// ----------------------------------------------------------------------------
// lfsr_seed_key_calc_unit
// 24-bit security-access key from access level and 8-byte seed
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfsr_seed_key_calc_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lskc_pkg::LEVEL_W-1:0]      s_access_level,
    input  logic [lskc_pkg::HALF_W-1:0]       s_seed_low,
    input  logic [lskc_pkg::HALF_W-1:0]       s_seed_high,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lskc_pkg::LFSR_W-1:0]       m_key_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lskc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [lskc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    lskc_pkg::lfsr_t  start_reg;
    lskc_pkg::fill_t  fill_one_reg;
    lskc_pkg::fill_t  fill_three_reg;
    lskc_pkg::fill_t  fill_sixty_one_reg;

    logic             in_valid_reg;
    lskc_pkg::level_t level_reg;
    lskc_pkg::seed_t  seed_reg;

    logic             out_valid_reg;
    lskc_pkg::lfsr_t  key_reg;

    logic             adv_out;
    lskc_pkg::fill_t  fill_sel;
    logic             use_fill;
    lskc_pkg::seed_t  seed_eff;
    lskc_pkg::lfsr_t  lfsr_final;
    lskc_pkg::lfsr_t  key_next;

    assign cfg_ready = 1'b1;
    assign adv_out   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || adv_out;
    assign m_valid   = out_valid_reg;
    assign m_key_out = key_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg          <= lskc_pkg::START_RESET;
            fill_one_reg       <= lskc_pkg::FILL_ONE_RESET;
            fill_three_reg     <= lskc_pkg::FILL_THREE_RESET;
            fill_sixty_one_reg <= lskc_pkg::FILL_SIXTY_ONE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                lskc_pkg::CFG_LFSR_START: begin
                    start_reg <= cfg_wdata[lskc_pkg::LFSR_W-1:0];
                end
                lskc_pkg::CFG_LEVEL_ONE_FILL: begin
                    fill_one_reg <= cfg_wdata[lskc_pkg::FILL_W-1:0];
                end
                lskc_pkg::CFG_LEVEL_THREE_FILL: begin
                    fill_three_reg <= cfg_wdata[lskc_pkg::FILL_W-1:0];
                end
                lskc_pkg::CFG_LEVEL_SIXTY_ONE_FILL: begin
                    fill_sixty_one_reg <= cfg_wdata[lskc_pkg::FILL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_access_level;
            seed_reg  <= {s_seed_high, s_seed_low};
        end
    end

    // level fill select
    always_comb begin
        use_fill = 1'b1;
        fill_sel = '0;
        unique case (level_reg)
            lskc_pkg::LEVEL_ONE:       fill_sel = fill_one_reg;
            lskc_pkg::LEVEL_THREE:     fill_sel = fill_three_reg;
            lskc_pkg::LEVEL_SIXTY_ONE: fill_sel = fill_sixty_one_reg;
            default:                   use_fill = 1'b0;
        endcase
        seed_eff = use_fill ? {fill_sel, seed_reg[lskc_pkg::KEEP_W-1:0]} : seed_reg;
    end

    // unrolled shift register as parity over start and seed bits
    always_comb begin
        for (int j = 0; j < lskc_pkg::LFSR_W; j++) begin
            lfsr_final[j] = (^(start_reg & lskc_pkg::START_MATRIX[j]))
                          ^ (^(seed_eff & lskc_pkg::SEED_MATRIX[j]));
        end
        key_next = lskc_pkg::key_shuffle(lfsr_final);
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && in_valid_reg) begin
            key_reg <= key_next;
        end
    end

    `ASSERT_NEXT(a_in_load, s_valid && s_ready, in_valid_reg)
    `ASSERT_NEXT(a_out_load, in_valid_reg && adv_out, out_valid_reg)
    `ASSERT_NEXT(a_in_hold, in_valid_reg && !adv_out, in_valid_reg && $stable(seed_reg))
    `ASSERT_IMPLY(a_ready_free, !in_valid_reg, s_ready)
    `ASSERT_NEXT(a_start_write, cfg_valid && cfg_addr == lskc_pkg::CFG_LFSR_START,
                 start_reg == $past(cfg_wdata[lskc_pkg::LFSR_W-1:0]))

endmodule
